### design/spq_pkg.sv
// Package for the sorted priority queue: sizes, command and error codes,
// the APB request bundle and the ring-address helper.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

  // Store size and derived widths.
  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Command codes carried by in_cmd.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_ORDER  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Error codes reported with each result.
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  // Register index of the threshold register (paddr[2] selects the register).
  localparam logic REG_THRESHOLD = 1'b0;

  // APB request bundle from the top level to the register block.
  typedef struct packed {
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
  } apb_req_t;

  // Physical address of a logical slot in the ring that starts at base.
  function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### design/spq_cfg.sv
// APB register block of the sorted priority queue: holds the restock threshold.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spq_pkg::apb_req_t             apb_req,
  output logic [spq_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output logic [spq_pkg::COUNT_W-1:0]   threshold
);
  import spq_pkg::*;

  logic [COUNT_W-1:0] threshold_r;
  logic [COUNT_W-1:0] threshold_nxt;
  logic               wr_beat;
  logic               reg_hit;

  // A write beat completes in the access phase; the port never waits.
  assign pready  = 1'b1;
  assign reg_hit = (apb_req.paddr[2] == REG_THRESHOLD);
  assign wr_beat = apb_req.psel && apb_req.penable && apb_req.pwrite;

  // Register update.
  always_comb begin
    threshold_nxt = threshold_r;
    if (wr_beat && reg_hit) begin
      threshold_nxt = apb_req.pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
    end else begin
      threshold_r <= threshold_nxt;
    end
  end

  // Read data: the threshold, zero-extended; nothing elsewhere.
  assign prdata    = reg_hit ? {{(DATA_W-COUNT_W){1'b0}}, threshold_r} : '0;
  assign threshold = threshold_r;

endmodule

### design/sorted_priority_queue_with_reorder_flag.sv
// Top level of the sorted priority queue with restock flag: command FSM,
// ring-buffer key memory and result register. Depends on spq_pkg and spq_cfg.
`timescale 1ns / 1ps

// Keys are kept in ascending order in a ring buffer held in one memory with a
// registered read port; the head key is also kept in a register. A command is
// taken when start is high and busy is low, and its result beat appears on the
// out_ ports, marked by out_valid, in the cycle in which busy falls (or in the
// cycle after the accept when busy never rises). The receiver cannot stall,
// and a new command may be issued in the same cycle as a result beat. Writing
// the order flag, the unused command, rejected commands and an insert into an
// empty store keep busy low. Removing the last key also keeps busy low;
// removing with two or more keys stored goes busy while the new head is read
// from memory. An insert walks down from the tail, one memory read per cycle,
// moving each key greater than the new one up by one slot; it stays busy until
// it meets a key that is not greater, or, when all stored keys are greater,
// until it has written the new key as the head.
module sorted_priority_queue_with_reorder_flag (
  input  logic                         clk,
  input  logic                         rst_n,
  // Command channel.
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_cmd,
  input  logic [spq_pkg::KEY_W-1:0]    in_expiry_time,
  input  logic                         in_order_value,
  // Result channel.
  output logic                         out_valid,
  output logic [spq_pkg::KEY_W-1:0]    out_head_time,
  output logic [spq_pkg::COUNT_W-1:0]  out_unit_count,
  output logic                         out_is_empty,
  output logic                         out_order_pending,
  output logic                         out_restock_needed,
  output logic [1:0]                   out_error_code,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spq_pkg::ADDR_W-1:0]   paddr,
  input  logic [spq_pkg::DATA_W-1:0]   pwdata,
  output logic [spq_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import spq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_INS0 = 4'b0100,
    S_REM  = 4'b1000
  } state_t;

  apb_req_t           apb_req;
  logic [COUNT_W-1:0] threshold;

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   base_r, base_nxt;
  logic               flag_r, flag_nxt;
  logic [KEY_W-1:0]   head_r, head_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;

  logic               fin;
  logic [1:0]         err;
  logic               we;
  logic [IDX_W-1:0]   wa;
  logic [KEY_W-1:0]   wd;
  logic [IDX_W-1:0]   ra;
  logic [KEY_W-1:0]   rdata_r;
  logic [KEY_W-1:0]   mem [DEPTH];

  logic               out_valid_r;
  logic [KEY_W-1:0]   out_head_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic               out_empty_r;
  logic               out_flag_r;
  logic               out_restock_r;
  logic [1:0]         out_err_r;

  logic [COUNT_W-1:0] last_cnt;
  logic               full;

  // Register block.
  assign apb_req = '{psel: psel, penable: penable, pwrite: pwrite,
                     paddr: paddr, pwdata: pwdata};

  spq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .apb_req   (apb_req),
    .prdata    (prdata),
    .pready    (pready),
    .threshold (threshold)
  );

  assign busy     = (state_r != S_IDLE);
  assign full     = (cnt_r == COUNT_W'(DEPTH));
  assign last_cnt = cnt_r - COUNT_W'(1);

  // Command sequencer: decodes a command, walks the store on an insert and
  // fetches the new head on a remove.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    base_nxt  = base_r;
    flag_nxt  = flag_r;
    head_nxt  = head_r;
    key_nxt   = key_r;
    j_nxt     = j_r;
    err       = ERR_OK;
    fin       = 1'b0;
    we        = 1'b0;
    wa        = ring_addr(base_r, j_r);
    wd        = key_r;
    ra        = ring_addr(base_r, j_r);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_t'(in_cmd))
            CMD_INSERT: begin
              if (full) begin
                err = ERR_FULL;
                fin = 1'b1;
              end else if (cnt_r == '0) begin
                we       = 1'b1;
                wa       = ring_addr(base_r, '0);
                wd       = in_expiry_time;
                head_nxt = in_expiry_time;
                cnt_nxt  = COUNT_W'(1);
                fin      = 1'b1;
              end else begin
                ra        = ring_addr(base_r, last_cnt[IDX_W-1:0]);
                j_nxt     = last_cnt[IDX_W-1:0];
                key_nxt   = in_expiry_time;
                state_nxt = S_INS;
              end
            end
            CMD_REMOVE: begin
              if (cnt_r == '0) begin
                err = ERR_EMPTY;
                fin = 1'b1;
              end else if (cnt_r == COUNT_W'(1)) begin
                cnt_nxt = '0;
                fin     = 1'b1;
              end else begin
                ra        = ring_addr(base_r, IDX_W'(1));
                state_nxt = S_REM;
              end
            end
            CMD_ORDER: begin
              flag_nxt = in_order_value;
              fin      = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_INS: begin
        // rdata_r holds logical slot j_r; a greater key moves up one slot.
        we = 1'b1;
        wa = ring_addr(base_r, j_r + IDX_W'(1));
        if (rdata_r > key_r) begin
          wd = rdata_r;
          if (j_r == '0) begin
            state_nxt = S_INS0;
          end else begin
            ra    = ring_addr(base_r, j_r - IDX_W'(1));
            j_nxt = j_r - IDX_W'(1);
          end
        end else begin
          wd        = key_r;
          cnt_nxt   = cnt_r + COUNT_W'(1);
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INS0: begin
        // Every stored key was greater: the new key becomes the head.
        we        = 1'b1;
        wa        = ring_addr(base_r, '0);
        wd        = key_r;
        head_nxt  = key_r;
        cnt_nxt   = cnt_r + COUNT_W'(1);
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      S_REM: begin
        // rdata_r holds the second key, which becomes the head.
        head_nxt  = rdata_r;
        base_nxt  = ring_addr(base_r, IDX_W'(1));
        cnt_nxt   = last_cnt;
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      base_r      <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      base_r      <= base_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= fin;
    end
  end

  // Payload registers and the result beat.
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    key_r  <= key_nxt;
    j_r    <= j_nxt;
    if (fin) begin
      out_head_r    <= (cnt_nxt == '0) ? '0 : head_nxt;
      out_cnt_r     <= cnt_nxt;
      out_empty_r   <= (cnt_nxt == '0);
      out_flag_r    <= flag_nxt;
      out_restock_r <= (cnt_nxt < threshold) && !flag_nxt;
      out_err_r     <= err;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_head_time      = out_head_r;
  assign out_unit_count     = out_cnt_r;
  assign out_is_empty       = out_empty_r;
  assign out_order_pending  = out_flag_r;
  assign out_restock_needed = out_restock_r;
  assign out_error_code     = out_err_r;

`ifndef ASSERT_OFF
  // A result beat only appears once the sequencer has gone idle.
  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // Writing the order flag answers in the next cycle with the new flag.
  a_order_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_ORDER) |=>
      (out_valid && out_order_pending == $past(in_order_value)))
    else $error("order flag write not reported");

  // A rejected insert reports a full store.
  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code == ERR_FULL) |-> (out_unit_count == COUNT_W'(DEPTH)))
    else $error("full error with store not full");

  // An empty store reports a zero head and a zero count.
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_head_time == '0 && out_unit_count == '0))
    else $error("empty store with nonzero head or count");
`endif

endmodule

### tb/tb_sorted_priority_queue_with_reorder_flag.sv
// Self-checking bench for the sorted priority queue with restock flag: a directed
// table, then random insert/remove/order phases checked against a local model.
// Depends on spq_pkg and the sorted_priority_queue_with_reorder_flag RTL.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_with_reorder_flag;
  import spq_pkg::*;

  localparam int ITEM_TARGET = 1550;
  localparam int CALM_ITEMS  = 200;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 80;
  localparam int N_DIRECTED  = 23;

  // Register map: the threshold at index 0, index 1 is unmapped.
  localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = 3'd0;
  localparam logic [ADDR_W-1:0] SPARE_ADDR     = 3'd4;

  // One status beat as the block reports it.
  typedef struct packed {
    logic [KEY_W-1:0]   head;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               pending;
    logic               restock;
    logic [1:0]         err;
  } status_t;

  typedef struct {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic             ov;
    bit               typed;
    status_t          status;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_cmd;
  logic [KEY_W-1:0]    in_expiry_time;
  logic                in_order_value;
  logic                out_valid;
  logic [KEY_W-1:0]    out_head_time;
  logic [COUNT_W-1:0]  out_unit_count;
  logic                out_is_empty;
  logic                out_order_pending;
  logic                out_restock_needed;
  logic [1:0]          out_error_code;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Model state: keys in ascending order, the order flag and the threshold.
  logic [KEY_W-1:0]    sorted_keys[$];
  logic                order_flag_q;
  logic [COUNT_W-1:0]  restock_threshold;

  status_t             status_due[$];
  int                  fail_count;
  int                  commands_sent;
  int                  stall_cycles;
  bit                  pause_on;

  // Directed table; rows with typed set carry their expected status.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, 1'b1, '{32'h0, 7'd0, 1'b1, 1'b0, 1'b0, ERR_EMPTY}},
    '{CMD_NONE,   32'hFFFF_FFFF, 1'b1, 1'b1, '{32'h0, 7'd0, 1'b1, 1'b0, 1'b0, ERR_OK}},
    '{CMD_ORDER,  32'h0000_0000, 1'b1, 1'b1, '{32'h0, 7'd0, 1'b1, 1'b1, 1'b0, ERR_OK}},
    '{CMD_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{32'hFFFF_FFFF, 7'd1, 1'b0, 1'b1, 1'b0, ERR_OK}},
    '{CMD_INSERT, 32'h0000_0000, 1'b0, 1'b1, '{32'h0, 7'd2, 1'b0, 1'b1, 1'b0, ERR_OK}},
    '{CMD_INSERT, 32'h0000_0000, 1'b1, 1'b1, '{32'h0, 7'd3, 1'b0, 1'b1, 1'b0, ERR_OK}},
    '{CMD_ORDER,  32'h0000_0000, 1'b0, 1'b1, '{32'h0, 7'd3, 1'b0, 1'b0, 1'b0, ERR_OK}},
    '{CMD_INSERT, 32'h8000_0000, 1'b0, 1'b0, '0},
    '{CMD_INSERT, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{CMD_INSERT, 32'h5555_5555, 1'b0, 1'b0, '0},
    '{CMD_INSERT, 32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{CMD_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, 1'b1, '{32'h0, 7'd0, 1'b1, 1'b0, 1'b0, ERR_EMPTY}},
    '{CMD_ORDER,  32'h0000_0000, 1'b1, 1'b1, '{32'h0, 7'd0, 1'b1, 1'b1, 1'b0, ERR_OK}},
    '{CMD_ORDER,  32'h0000_0000, 1'b0, 1'b1, '{32'h0, 7'd0, 1'b1, 1'b0, 1'b0, ERR_OK}}
  };

  sorted_priority_queue_with_reorder_flag dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_expiry_time     (in_expiry_time),
    .in_order_value     (in_order_value),
    .out_valid          (out_valid),
    .out_head_time      (out_head_time),
    .out_unit_count     (out_unit_count),
    .out_is_empty       (out_is_empty),
    .out_order_pending  (out_order_pending),
    .out_restock_needed (out_restock_needed),
    .out_error_code     (out_error_code),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one command to the model and return the status it should report.
  function automatic status_t apply_command(input cmd_t c, input logic [KEY_W-1:0] key,
                                            input logic ov);
    status_t s;
    int      pos;
    s = '0;
    s.err = ERR_OK;
    case (c)
      CMD_INSERT: begin
        if (sorted_keys.size() >= DEPTH) begin
          s.err = ERR_FULL;
        end else begin
          // Equal keys queue up behind the ones already stored.
          pos = 0;
          while (pos < sorted_keys.size() && sorted_keys[pos] <= key) pos++;
          sorted_keys.insert(pos, key);
        end
      end
      CMD_REMOVE: begin
        if (sorted_keys.size() == 0) begin
          s.err = ERR_EMPTY;
        end else begin
          void'(sorted_keys.pop_front());
        end
      end
      CMD_ORDER: begin
        order_flag_q = ov;
      end
      default: begin
      end
    endcase
    s.count   = COUNT_W'(sorted_keys.size());
    s.empty   = (sorted_keys.size() == 0);
    s.head    = s.empty ? '0 : sorted_keys[0];
    s.pending = order_flag_q;
    s.restock = (s.count < restock_threshold) && !order_flag_q;
    return s;
  endfunction

  // Offer one command beat and hold it until the block takes it.
  task automatic issue(input cmd_t c, input logic [KEY_W-1:0] key, input logic ov,
                       input bit typed, input status_t typed_status);
    status_t s;
    start          <= 1'b1;
    in_cmd         <= c;
    in_expiry_time <= key;
    in_order_value <= ov;
    do @(posedge clk); while (busy !== 1'b0);
    s = apply_command(c, key, ov);
    status_due.push_back(typed ? typed_status : s);
    commands_sent++;
  endtask

  // Sometimes let the command side go quiet for a burst of cycles.
  task automatic maybe_pause();
    if (pause_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Keys lean toward extremes and repeats so that ties and edges show up.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return KEY_W'($urandom_range(0, 15));
      5: begin
        if (sorted_keys.size() != 0) begin
          return sorted_keys[$urandom_range(0, sorted_keys.size() - 1)];
        end
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic random_command(input int insert_pct);
    int   r;
    cmd_t c;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      c = CMD_NONE;
    end else if (r < 10) begin
      c = CMD_ORDER;
    end else if ($urandom_range(0, 99) < insert_pct) begin
      c = CMD_INSERT;
    end else begin
      c = CMD_REMOVE;
    end
    issue(c, pick_key(), 1'($urandom_range(0, 1)), 1'b0, '0);
    maybe_pause();
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input bit wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd;
    apb_access(1'b1, addr, data, rd);
    if (addr == THRESHOLD_ADDR) restock_threshold = data[COUNT_W-1:0];
  endtask

  task automatic check_threshold_readback();
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, THRESHOLD_ADDR, '0, rd);
    if (rd !== DATA_W'(restock_threshold)) begin
      $error("prdata: expected %h, got %h", DATA_W'(restock_threshold), rd);
      fail_count++;
    end
  endtask

  // Park the command side until every outstanding status beat is back.
  task automatic drain_results();
    start <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
  endtask

  // Compare every status beat with the oldest outstanding prediction.
  always @(posedge clk) begin : status_check
    status_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (status_due.size() == 0) begin
        $error("status beat with no command outstanding");
        fail_count++;
      end else begin
        want = status_due.pop_front();
        if (out_head_time !== want.head) begin
          $error("head_time: expected %h, got %h", want.head, out_head_time);
          fail_count++;
        end
        if (out_unit_count !== want.count) begin
          $error("unit_count: expected %0d, got %0d", want.count, out_unit_count);
          fail_count++;
        end
        if (out_is_empty !== want.empty) begin
          $error("is_empty: expected %b, got %b", want.empty, out_is_empty);
          fail_count++;
        end
        if (out_order_pending !== want.pending) begin
          $error("order_pending: expected %b, got %b", want.pending, out_order_pending);
          fail_count++;
        end
        if (out_restock_needed !== want.restock) begin
          $error("restock_needed: expected %b, got %b", want.restock, out_restock_needed);
          fail_count++;
        end
        if (out_error_code !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, out_error_code);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without a command or status beat ends the run.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int phase_idx;
    int extra;
    int len;
    int pct;
    logic [COUNT_W-1:0] th;

    rst_n             = 1'b0;
    start             = 1'b0;
    in_cmd            = CMD_NONE;
    in_expiry_time    = '0;
    in_order_value    = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    order_flag_q      = 1'b0;
    restock_threshold = '0;
    fail_count        = 0;
    commands_sent     = 0;
    stall_cycles      = 0;
    pause_on          = 1'b1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Threshold must come out of reset at zero.
    check_threshold_readback();

    // Directed part: empty and full edges of the key range, ties, all commands.
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].ov,
            directed_rows[i].typed, directed_rows[i].status);
      maybe_pause();
    end

    // Random phases: mixed traffic, fill to overflow, drain past empty.
    phase_idx = 0;
    while (commands_sent < ITEM_TARGET) begin
      drain_results();

      case (phase_idx % 5)
        0: th = COUNT_W'(DEPTH);
        1: th = '0;
        default: th = COUNT_W'($urandom_range(0, DEPTH));
      endcase
      write_reg(THRESHOLD_ADDR, DATA_W'(th));
      if (phase_idx == 0 || $urandom_range(0, 1) == 0) write_reg(SPARE_ADDR, $urandom);
      check_threshold_readback();

      // The closing stretch of the run keeps the command side saturated.
      pause_on = (commands_sent < ITEM_TARGET - CALM_ITEMS) && ($urandom_range(0, 3) != 0);

      if (phase_idx % 4 == 1) begin
        extra = $urandom_range(1, 6);
        while (sorted_keys.size() < DEPTH || extra > 0) begin
          if (sorted_keys.size() == DEPTH) extra--;
          random_command(95);
        end
      end else if (phase_idx % 4 == 3) begin
        extra = $urandom_range(1, 5);
        while (sorted_keys.size() > 0 || extra > 0) begin
          if (sorted_keys.size() == 0) extra--;
          random_command(5);
        end
      end else begin
        len = $urandom_range(40, 120);
        pct = $urandom_range(35, 65);
        repeat (len) random_command(pct);
      end
      phase_idx++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (status_due.size() != 0) begin
      $error("%0d status beats never arrived", status_due.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/spq_pkg.sv
design/spq_cfg.sv
design/sorted_priority_queue_with_reorder_flag.sv
tb/tb_sorted_priority_queue_with_reorder_flag.sv
